>>> hdl/xrr_pkg.sv
package xrr_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned BOUND_W  = 31;
    localparam int unsigned WORD_CNT = 5;
    localparam int unsigned IDX_W    = 3;

    localparam logic [WORD_W-1:0] WEYL_STEP = 32'd362437;

    // seed register indexes
    localparam logic [IDX_W-1:0] REG_SEED_ZERO  = 3'd0;
    localparam logic [IDX_W-1:0] REG_SEED_ONE   = 3'd1;
    localparam logic [IDX_W-1:0] REG_SEED_TWO   = 3'd2;
    localparam logic [IDX_W-1:0] REG_SEED_THREE = 3'd3;
    localparam logic [IDX_W-1:0] REG_SEED_FOUR  = 3'd4;

    localparam logic [WORD_W-1:0] SEED_ZERO_RST  = 32'd123456789;
    localparam logic [WORD_W-1:0] SEED_ONE_RST   = 32'd362436069;
    localparam logic [WORD_W-1:0] SEED_TWO_RST   = 32'd521288629;
    localparam logic [WORD_W-1:0] SEED_THREE_RST = 32'd88675123;
    localparam logic [WORD_W-1:0] SEED_FOUR_RST  = 32'd5783321;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  index;
        logic [WORD_W-1:0] data;
    } cfg_write_t;

endpackage

>>> hdl/xorwow_ranged_random.sv
// channel  | handshake                     | payload
// ---------+-------------------------------+---------------------------------------------
// s_axis   | s_axis_tvalid / s_axis_tready | tdata: lower_bound[30:0], upper_bound[61:31]
// m_axis   | m_axis_tvalid / m_axis_tready | tdata: ranged_value[30:0], raw_word[62:31]
//          |                               | tuser: range_error
// cfg      | cfg_we (no wait)              | cfg_index (seed 0..4), cfg_data
//
// After the accepting edge the block takes one generator step, loads the divider, runs the
// one-bit-per-cycle restoring modulo and adds the lower bound; it accepts no new request
// until it is back in idle.
// A range error skips the step and divider and goes straight to the result state.
// Reset clears the counter and loads the five default seeds; no clearing pass.
// A stalled result sits in the output register; the next transaction runs meanwhile
// and waits in its last cycle until that register frees up.
module xorwow_ranged_random
    import xrr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [63:0]         s_axis_tdata,  // lower_bound, upper_bound
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [63:0]         m_axis_tdata,  // ranged_value, raw_word
    output logic                m_axis_tuser,  // range_error
    input  logic                cfg_we,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [WORD_W-1:0]   cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_STEP = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [BOUND_W-1:0] lower_reg;
    logic [WORD_W-1:0]  span_reg;
    logic               err_reg;
    logic [WORD_W-1:0]  raw_reg;

    logic               out_valid_reg;
    logic [BOUND_W-1:0] out_ranged_reg;
    logic [WORD_W-1:0]  out_raw_reg;
    logic               out_err_reg;

    logic [BOUND_W-1:0] in_lower, in_upper;
    logic               accept;
    logic               out_free;
    logic               finish;
    cfg_write_t         cfg;
    logic               mod_start;
    logic               mod_done;
    logic               gen_step;
    logic [WORD_W-1:0]  gen_raw;
    logic [BOUND_W-1:0] mod_rem;

    assign in_lower = s_axis_tdata[BOUND_W-1:0];
    assign in_upper = s_axis_tdata[2*BOUND_W-1:BOUND_W];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign finish        = (state_reg == ST_DONE) && out_free;

    assign cfg = '{we: cfg_we, index: cfg_index, data: cfg_data};

    assign gen_step  = (state_reg == ST_STEP);
    assign mod_start = (state_reg == ST_LOAD);

    xrr_gen u_gen
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .step     (gen_step),
        .raw_word (gen_raw)
    );

    xrr_mod u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (gen_raw),
        .divisor   (span_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = (in_upper < in_lower) ? ST_DONE : ST_STEP;
            end
            ST_STEP: state_next = ST_LOAD;
            ST_LOAD: state_next = ST_DIV;
            ST_DIV:
            begin
                if (mod_done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lower_reg <= in_lower;
            // span reaches 2^31 at most
            span_reg  <= {1'b0, in_upper} - {1'b0, in_lower} + 32'd1;
            err_reg   <= (in_upper < in_lower);
        end
        if (mod_start)
            raw_reg <= gen_raw;
        if (finish)
        begin
            out_err_reg <= err_reg;
            if (err_reg)
            begin
                out_ranged_reg <= '0;
                out_raw_reg    <= '0;
            end
            else
            begin
                out_ranged_reg <= lower_reg + mod_rem;
                out_raw_reg    <= raw_reg;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_raw_reg, out_ranged_reg};
    assign m_axis_tuser  = out_err_reg;

endmodule

>>> hdl/xrr_gen.sv
module xrr_gen
    import xrr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_write_t        cfg,
    input  logic              step,
    output logic [WORD_W-1:0] raw_word
);

    logic [WORD_W-1:0] word0_reg, word1_reg, word2_reg, word3_reg, word4_reg;
    logic [WORD_W-1:0] counter_reg;
    logic [WORD_W-1:0] t_a, t_b, t_next;

    // word0 is the newest word, word4 the oldest
    always_comb
    begin
        t_a    = word4_reg ^ (word4_reg >> 2);
        t_b    = t_a ^ (t_a << 1);
        t_next = t_b ^ word0_reg ^ (word0_reg << 4);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word0_reg   <= SEED_ZERO_RST;
            word1_reg   <= SEED_ONE_RST;
            word2_reg   <= SEED_TWO_RST;
            word3_reg   <= SEED_THREE_RST;
            word4_reg   <= SEED_FOUR_RST;
            counter_reg <= '0;
        end
        else if (cfg.we)
        begin
            unique case (cfg.index)
                REG_SEED_ZERO:
                begin
                    word0_reg   <= cfg.data;
                    counter_reg <= '0;
                end
                REG_SEED_ONE:
                begin
                    word1_reg   <= cfg.data;
                    counter_reg <= '0;
                end
                REG_SEED_TWO:
                begin
                    word2_reg   <= cfg.data;
                    counter_reg <= '0;
                end
                REG_SEED_THREE:
                begin
                    word3_reg   <= cfg.data;
                    counter_reg <= '0;
                end
                REG_SEED_FOUR:
                begin
                    word4_reg   <= cfg.data;
                    counter_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (step)
        begin
            word4_reg   <= word3_reg;
            word3_reg   <= word2_reg;
            word2_reg   <= word1_reg;
            word1_reg   <= word0_reg;
            word0_reg   <= t_next;
            counter_reg <= counter_reg + WEYL_STEP;
        end
    end

    // valid after a step: newest word plus counter
    assign raw_word = word0_reg + counter_reg;

endmodule

>>> hdl/xrr_mod.sv
module xrr_mod
    import xrr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [WORD_W-1:0]  dividend,
    input  logic [WORD_W-1:0]  divisor,
    output logic               done,
    output logic [BOUND_W-1:0] remainder
);

    localparam int unsigned CNT_W = $clog2(WORD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

    logic               busy_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [WORD_W-1:0]  dvd_reg;
    logic [WORD_W-1:0]  dvs_reg;
    logic [BOUND_W-1:0] rem_reg;
    logic [BOUND_W-1:0] rem_next;
    logic [WORD_W-1:0]  trial;
    logic [WORD_W-1:0]  diff;

    // restoring step: remainder stays below divisor <= 2^31, so 31 bits hold it
    always_comb
    begin
        trial = {rem_reg, dvd_reg[WORD_W-1]};
        diff  = trial - dvs_reg;
        if (trial >= dvs_reg)
            rem_next = diff[BOUND_W-1:0];
        else
            rem_next = trial[BOUND_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            count_reg <= '0;
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg + 1'b1;
            if (count_reg == CNT_LAST)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[WORD_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = busy_reg && (count_reg == CNT_LAST);
    assign remainder = rem_reg;

endmodule

>>> sim/xrr_checker.sv
`timescale 1ns / 1ps

// Watches the request, result and seed write channels, runs its own xorwow
// model and compares every result transaction against the oldest prediction.
module xrr_checker
    import xrr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic [63:0]       s_axis_tdata,  // lower_bound, upper_bound
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [63:0]       m_axis_tdata,  // ranged_value, raw_word
    input  logic              m_axis_tuser,  // range_error
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [WORD_W-1:0] cfg_data,
    output int                outstanding,
    output int                fail_count
);

    typedef struct packed {
        logic [BOUND_W-1:0] ranged;
        logic [WORD_W-1:0]  raw;
        logic               range_err;
    } draw_t;

    // index 0 holds the newest word, index 4 the oldest
    logic [WORD_W-1:0] xw_words [WORD_CNT];
    logic [WORD_W-1:0] weyl;
    draw_t             draws_due [$];
    int                fails;

    function automatic draw_t predict_draw(input logic [BOUND_W-1:0] lo,
                                           input logic [BOUND_W-1:0] hi);
        draw_t             d;
        logic [WORD_W-1:0] t;
        logic [WORD_W-1:0] s;
        logic [WORD_W-1:0] span;
        logic [WORD_W-1:0] rem;
        d = '0;
        if (hi < lo)
        begin
            // bad range: flag only, generator holds still
            d.range_err = 1'b1;
            return d;
        end
        t = xw_words[4];
        s = xw_words[0];
        for (int i = 4; i > 1; i--)
            xw_words[i] = xw_words[i-1];
        xw_words[1] = s;
        t = t ^ (t >> 2);
        t = t ^ (t << 1);
        t = t ^ s ^ (s << 4);
        xw_words[0] = t;
        weyl = weyl + WEYL_STEP;
        d.raw = t + weyl;
        // span reaches 2^31 for the full range, so work in 32 bits
        span = {1'b0, hi} - {1'b0, lo} + 32'd1;
        rem = d.raw % span;
        d.ranged = lo + rem[BOUND_W-1:0];
        return d;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        draw_t want;
        if (!rst_n)
        begin
            xw_words[0] = SEED_ZERO_RST;
            xw_words[1] = SEED_ONE_RST;
            xw_words[2] = SEED_TWO_RST;
            xw_words[3] = SEED_THREE_RST;
            xw_words[4] = SEED_FOUR_RST;
            weyl = '0;
            draws_due.delete();
            fails = 0;
            outstanding <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (cfg_we && cfg_index < WORD_CNT)
            begin
                xw_words[cfg_index] = cfg_data;
                weyl = '0;
            end
            if (s_axis_tvalid && s_axis_tready)
                draws_due.push_back(predict_draw(s_axis_tdata[30:0], s_axis_tdata[61:31]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (draws_due.size() == 0)
                begin
                    $error("unexpected result transaction: tdata %h tuser %b",
                           m_axis_tdata, m_axis_tuser);
                    fails++;
                end
                else
                begin
                    want = draws_due.pop_front();
                    if (m_axis_tdata[30:0] !== want.ranged)
                    begin
                        $error("ranged_value: expected %0d, got %0d",
                               want.ranged, m_axis_tdata[30:0]);
                        fails++;
                    end
                    if (m_axis_tdata[62:31] !== want.raw)
                    begin
                        $error("raw_word: expected %h, got %h", want.raw, m_axis_tdata[62:31]);
                        fails++;
                    end
                    if (m_axis_tuser !== want.range_err)
                    begin
                        $error("range_error: expected %b, got %b", want.range_err, m_axis_tuser);
                        fails++;
                    end
                end
            end
            outstanding <= draws_due.size();
            fail_count <= fails;
        end
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import xrr_pkg::*;

    localparam logic [BOUND_W-1:0] BOUND_MAX = '1;
    localparam int                 CYCLE_LIMIT = 1000000;
    localparam int                 PHASES = 6;
    localparam int                 PHASE_ITEMS = 255;

    // indexes past the last seed register; writes there must be dropped
    localparam logic [IDX_W-1:0] REG_UNMAPPED_LO = 3'd5;
    localparam logic [IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    localparam logic [IDX_W-1:0] SEED_REGS [WORD_CNT] = '{
        REG_SEED_ZERO, REG_SEED_ONE, REG_SEED_TWO, REG_SEED_THREE, REG_SEED_FOUR
    };

    logic              clk;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [63:0]       s_axis_tdata;   // lower_bound[30:0], upper_bound[61:31]
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [63:0]       m_axis_tdata;   // ranged_value[30:0], raw_word[62:31]
    logic              m_axis_tuser;   // range_error
    logic              cfg_we;
    logic [IDX_W-1:0]  cfg_index;
    logic [WORD_W-1:0] cfg_data;

    int outstanding;
    int fail_count;
    int cycle_count = 0;
    int ready_hold = 0;
    int requests_sent = 0;
    int range_errs_sent = 0;
    int seed_settings = 1;
    bit gaps_on = 1'b1;
    bit stall_on = 1'b1;

    xorwow_ranged_random dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    xrr_checker draw_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .outstanding   (outstanding),
        .fail_count    (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("xorwow_ranged_random verification failed");
            $finish;
        end
    end

    // mostly short idles, now and then a long one
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(15, 60);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            ready_hold <= 0;
        end
        else if (ready_hold > 0)
        begin
            m_axis_tready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end
        else if (stall_on && $urandom_range(0, 99) < 20)
        begin
            m_axis_tready <= 1'b0;
            ready_hold <= pick_idle() - 1;
        end
        else
            m_axis_tready <= 1'b1;
    end

    task automatic send_bounds(input logic [BOUND_W-1:0] lo, input logic [BOUND_W-1:0] hi);
        int gap;
        gap = (gaps_on && $urandom_range(0, 99) < 40) ? pick_idle() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, hi, lo};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        requests_sent++;
        if (hi < lo)
            range_errs_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_seed(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    function automatic logic [WORD_W-1:0] pick_seed();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic load_seeds(input int phase);
        wait_idle();
        case (phase)
            0:
                foreach (SEED_REGS[k])
                    write_seed(SEED_REGS[k], '1);
            1:
                // all-zero shift words: raw output degenerates to the counter
                foreach (SEED_REGS[k])
                    write_seed(SEED_REGS[k], '0);
            default:
            begin
                foreach (SEED_REGS[k])
                    if ($urandom_range(0, 1))
                        write_seed(SEED_REGS[k], pick_seed());
                write_seed(IDX_W'($urandom_range(REG_UNMAPPED_HI, REG_UNMAPPED_LO)), $urandom);
                write_seed(SEED_REGS[IDX_W'($urandom_range(0, WORD_CNT - 1))], pick_seed());
            end
        endcase
        cfg_we <= 1'b0;
        seed_settings++;
    endtask

    task automatic random_request();
        logic [BOUND_W-1:0] a;
        logic [BOUND_W-1:0] b;
        logic [WORD_W-1:0]  span;
        int                 pick;
        a = BOUND_W'($urandom);
        b = BOUND_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            // inverted bounds
            if (a == b)
                b = a ^ 31'd1;
            if (a > b)
                send_bounds(a, b);
            else
                send_bounds(b, a);
        end
        else if (pick < 25)
            send_bounds('0, ($urandom_range(0, 1)) ? BOUND_MAX : b);
        else if (pick < 50)
            send_bounds(a, (a > BOUND_MAX - 31'd16) ? BOUND_MAX :
                           a + BOUND_W'($urandom_range(0, 15)));
        else if (pick < 65)
        begin
            span = 32'd1 << $urandom_range(0, 30);
            a = BOUND_W'($urandom_range(0, 32'h8000_0000 - span));
            send_bounds(a, a + BOUND_W'(span - 32'd1));
        end
        else if (a <= b)
            send_bounds(a, b);
        else
            send_bounds(b, a);
    endtask

    initial
    begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        cfg_we <= 1'b0;
        cfg_index <= REG_SEED_ZERO;
        cfg_data <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pass on the default seeds
        send_bounds('0, '0);
        send_bounds('0, BOUND_MAX);
        send_bounds(BOUND_MAX, BOUND_MAX);
        send_bounds(BOUND_MAX, '0);
        send_bounds(31'd1, '0);
        send_bounds(BOUND_MAX, BOUND_MAX - 31'd1);
        send_bounds('0, 31'd1);
        send_bounds(BOUND_MAX - 31'd1, BOUND_MAX);
        send_bounds(31'd12345, 31'd12345);
        send_bounds('0, 31'h3FFF_FFFF);
        send_bounds(31'h4000_0000, BOUND_MAX);
        send_bounds(31'h2AAA_AAAA, 31'h5555_5555);
        send_bounds(31'h5555_5555, 31'h2AAA_AAAA);
        send_bounds(31'd1, BOUND_MAX);
        send_bounds('0, BOUND_MAX - 31'd1);
        send_bounds(31'd100, 31'd99);
        send_bounds(31'd7, 31'd10);
        send_bounds('0, 31'd2);
        send_bounds(31'h7FFF_FFF0, BOUND_MAX);
        send_bounds('0, BOUND_MAX);

        for (int p = 0; p < PHASES; p++)
        begin
            load_seeds(p);
            // one phase runs back to back with no idles at all
            gaps_on = (p != 3);
            stall_on = (p != 3);
            repeat (PHASE_ITEMS) random_request();
        end

        wait_idle();
        $display("%0d requests (%0d with inverted bounds) across %0d seed settings",
                 requests_sent, range_errs_sent, seed_settings);
        $display("seeds covered all-ones, all-zero, random and unmapped-index writes");
        if (fail_count == 0)
            $display("xorwow_ranged_random verification clean");
        else
            $display("xorwow_ranged_random verification failed");
        $finish;
    end

endmodule
